// File: rtl/core/chained_hash_set_engine_top_defines.svh
// Assertion macros for the chained hash set engine.
`ifndef CHAINED_HASH_SET_ENGINE_TOP_DEFINES_SVH
`define CHAINED_HASH_SET_ENGINE_TOP_DEFINES_SVH

// Clocked assertion with asynchronous reset disable.
`define CHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CHS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/core/chs_pkg.sv
// Package with the operation codes and sequencer states of the hash set engine.
`timescale 1ns / 1ps
`default_nettype none
package chs_pkg;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned KindW  = 2;
  localparam int unsigned TotalW = 9;
  localparam int unsigned MixShift = 16;

  typedef enum logic [KindW-1:0] {
    OP_ADD    = 2'd0,
    OP_QUERY  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HASH,
    S_BREAD,
    S_BHEAD,
    S_NREQ,
    S_NCHK,
    S_DECIDE,
    S_FREQ,
    S_FGET,
    S_WRITE,
    S_LINK,
    S_UNLINK,
    S_RESP
  } state_e;

endpackage
`default_nettype wire

// File: rtl/core/chs_bucket_sel.sv
// Key mixer and bucket index unit: a mask for power-of-two counts, else a reciprocal remainder.
`timescale 1ns / 1ps
`default_nettype none
module chs_bucket_sel #(
  parameter int unsigned BUCKETS = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [chs_pkg::KeyW-1:0]    key_i,
  output logic                             done_o,
  output logic [$clog2(BUCKETS)-1:0]       bucket_o
);
  import chs_pkg::*;

  localparam int unsigned BW = $clog2(BUCKETS);
  localparam bit IsPow2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  logic [KeyW-1:0] mix;
  assign mix = key_i ^ (key_i >> MixShift);

  if (IsPow2) begin : g_mask
    logic          done_q;
    logic [BW-1:0] bkt_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        bkt_q <= mix[BW-1:0];
      end
    end

    assign done_o   = done_q;
    assign bucket_o = bkt_q;
  end else begin : g_recip
    // The remainder is built over 16-bit chunks of the mixed key. Each chunk is handled as
    // a multiply by the reciprocal of the bucket count, then a subtract and one correction.
    localparam int unsigned ChunkW = 16;
    localparam int unsigned Chunks = KeyW / ChunkW;
    localparam int unsigned CW     = $clog2(Chunks);
    localparam int unsigned VW     = BW + ChunkW;
    localparam logic [31:0] Recip  = 32'((64'd1 << 32) / 64'(BUCKETS));
    logic             busy_q;
    logic             phase_q;
    logic             done_q;
    logic [CW-1:0]    cnt_q;
    logic [KeyW-1:0]  sh_q;
    logic [BW-1:0]    rem_q;
    logic [VW-1:0]    val;
    logic [VW-1:0]    val_q;
    logic [VW+31:0]   prod_q;
    logic [VW-1:0]    quot;
    logic [VW-1:0]    back;
    logic [VW-1:0]    diff;
    logic [VW-1:0]    rem_next;

    assign val      = {rem_q, sh_q[KeyW-1 -: ChunkW]};
    assign quot     = prod_q[VW+31:32];
    assign back     = quot * VW'(BUCKETS);
    assign diff     = val_q - back;
    assign rem_next = (diff >= VW'(BUCKETS)) ? diff - VW'(BUCKETS) : diff;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q  <= 1'b0;
        phase_q <= 1'b0;
        done_q  <= 1'b0;
        cnt_q   <= '0;
      end else begin
        done_q <= 1'b0;
        if (start_i) begin
          busy_q  <= 1'b1;
          phase_q <= 1'b0;
          cnt_q   <= '0;
        end else if (busy_q) begin
          phase_q <= ~phase_q;
          if (phase_q) begin
            cnt_q <= cnt_q + CW'(1);
            if (cnt_q == CW'(Chunks - 1)) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        sh_q  <= mix;
        rem_q <= '0;
      end else if (busy_q) begin
        if (!phase_q) begin
          prod_q <= (VW + 32)'(val) * (VW + 32)'(Recip);
          val_q  <= val;
        end else begin
          rem_q <= rem_next[BW-1:0];
          sh_q  <= sh_q << ChunkW;
        end
      end
    end

    assign done_o   = done_q;
    assign bucket_o = rem_q;
  end

endmodule
`default_nettype wire

// File: rtl/core/chs_node_store.sv
// Node pool memories holding each node's key and link, with registered reads.
`timescale 1ns / 1ps
`default_nettype none
module chs_node_store #(
  parameter int unsigned CAPACITY = 256
) (
  input  wire logic                               clk_i,
  input  wire logic [$clog2(CAPACITY)-1:0]        raddr_i,
  input  wire logic [$clog2(CAPACITY)-1:0]        waddr_i,
  input  wire logic                               key_we_i,
  input  wire logic [chs_pkg::KeyW-1:0]           key_wdata_i,
  input  wire logic                               link_we_i,
  input  wire logic [$clog2(CAPACITY+1)-1:0]      link_wdata_i,
  output logic [chs_pkg::KeyW-1:0]                key_rdata_o,
  output logic [$clog2(CAPACITY+1)-1:0]           link_rdata_o
);
  import chs_pkg::*;

  localparam int unsigned NW = $clog2(CAPACITY + 1);

  logic [KeyW-1:0] key_mem [CAPACITY];
  logic [NW-1:0]   link_mem [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (key_we_i) begin
      key_mem[waddr_i] <= key_wdata_i;
    end
    key_rdata_o <= key_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (link_we_i) begin
      link_mem[waddr_i] <= link_wdata_i;
    end
    link_rdata_o <= link_mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/core/chained_hash_set_engine_top.sv
// Sequence: after the accepting edge come bucket selection, the bucket head read, a compare
// for each chain node, a last node request in S_NREQ at the end of a walk that misses, then a
// decision state and the update states (S_FREQ, S_FGET, S_WRITE, S_LINK for an add, S_UNLINK
// for a remove); the result then stays until taken. A clear goes straight to the result state.
// Throughput: one operation at a time; the chain walk through the node memory sets the rate.
// Reset empties every bucket and the free list and zeroes the key count at once.
`timescale 1ns / 1ps
`default_nettype none
`include "chained_hash_set_engine_top_defines.svh"
module chained_hash_set_engine_top #(
  parameter int unsigned BUCKETS  = 64,
  parameter int unsigned CAPACITY = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [chs_pkg::KindW-1:0]     kind_i,
  input  wire logic [chs_pkg::KeyW-1:0]      key_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               found_o,
  output logic                               rejected_full_o,
  output logic [chs_pkg::TotalW-1:0]         item_total_o
);
  import chs_pkg::*;

  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned NW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam logic [NW-1:0] Nil = NW'(CAPACITY);

  state_e state_q, state_d;

  op_e             op_q;
  logic [KeyW-1:0] key_q;
  logic [BW-1:0]   bkt_q;
  logic [NW-1:0]   cur_q, prev_q, new_q, steps_q;
  logic [NW-1:0]   free_q, fresh_q, count_q;
  logic            found_q, rej_q;
  logic [BUCKETS-1:0] bvalid_q;
  logic [NW-1:0]   bkt_mem [BUCKETS];
  logic [NW-1:0]   bkt_rd_q;

  logic            hash_start, hash_done;
  logic [BW-1:0]   hash_bkt;
  logic [AW-1:0]   nd_raddr, nd_waddr;
  logic            key_we, link_we;
  logic [NW-1:0]   link_wdata;
  logic [KeyW-1:0] key_rd;
  logic [NW-1:0]   link_rd;
  logic            bkt_we;
  logic [NW-1:0]   bkt_wdata;
  logic            in_fire, out_fire;
  logic [NW+TotalW-1:0] count_ext;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  chs_bucket_sel #(.BUCKETS(BUCKETS)) u_bucket_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (key_i),
    .done_o  (hash_done),
    .bucket_o(hash_bkt)
  );

  chs_node_store #(.CAPACITY(CAPACITY)) u_node_store (
    .clk_i       (clk_i),
    .raddr_i     (nd_raddr),
    .waddr_i     (nd_waddr),
    .key_we_i    (key_we),
    .key_wdata_i (key_q),
    .link_we_i   (link_we),
    .link_wdata_i(link_wdata),
    .key_rdata_o (key_rd),
    .link_rdata_o(link_rd)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (op_e'(kind_i) == OP_CLEAR) ? S_RESP : S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          state_d = S_BREAD;
        end
      end
      S_BREAD: state_d = S_BHEAD;
      S_BHEAD: state_d = S_NREQ;
      S_NREQ: begin
        if (cur_q == Nil || steps_q == NW'(CAPACITY)) begin
          state_d = S_DECIDE;
        end else begin
          state_d = S_NCHK;
        end
      end
      S_NCHK: state_d = (key_rd == key_q) ? S_DECIDE : S_NREQ;
      S_DECIDE: begin
        state_d = S_RESP;
        if (op_q == OP_ADD && !found_q) begin
          if (free_q != Nil) begin
            state_d = S_FREQ;
          end else if (fresh_q != NW'(CAPACITY)) begin
            state_d = S_WRITE;
          end
        end else if (op_q == OP_REMOVE && found_q) begin
          state_d = S_UNLINK;
        end
      end
      S_FREQ:   state_d = S_FGET;
      S_FGET:   state_d = S_WRITE;
      S_WRITE:  state_d = (prev_q != Nil) ? S_LINK : S_RESP;
      S_LINK:   state_d = S_RESP;
      S_UNLINK: state_d = S_RESP;
      S_RESP: begin
        if (out_fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    out_valid_o = (state_q == S_RESP);
    hash_start  = (state_q == S_IDLE) && in_fire && (op_e'(kind_i) != OP_CLEAR);
    nd_raddr    = (state_q == S_FREQ) ? free_q[AW-1:0] : cur_q[AW-1:0];
    nd_waddr    = prev_q[AW-1:0];
    key_we      = 1'b0;
    link_we     = 1'b0;
    link_wdata  = Nil;
    bkt_we      = 1'b0;
    bkt_wdata   = Nil;
    case (state_q)
      S_DECIDE: begin
        if (op_q == OP_REMOVE && found_q) begin
          if (prev_q != Nil) begin
            link_we    = 1'b1;
            link_wdata = link_rd;
          end else begin
            bkt_we    = 1'b1;
            bkt_wdata = link_rd;
          end
        end
      end
      S_UNLINK: begin
        link_we    = 1'b1;
        nd_waddr   = cur_q[AW-1:0];
        link_wdata = free_q;
      end
      S_WRITE: begin
        key_we     = 1'b1;
        link_we    = 1'b1;
        nd_waddr   = new_q[AW-1:0];
        link_wdata = Nil;
        if (prev_q == Nil) begin
          bkt_we    = 1'b1;
          bkt_wdata = new_q;
        end
      end
      S_LINK: begin
        link_we    = 1'b1;
        link_wdata = new_q;
      end
      default: begin
        link_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      bvalid_q <= '0;
      free_q   <= Nil;
      fresh_q  <= '0;
      count_q  <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire && op_e'(kind_i) == OP_CLEAR) begin
        bvalid_q <= '0;
        free_q   <= Nil;
        fresh_q  <= '0;
        count_q  <= '0;
      end
      if (bkt_we) begin
        bvalid_q[bkt_q] <= 1'b1;
      end
      if (state_q == S_DECIDE && op_q == OP_ADD && !found_q && free_q == Nil &&
          fresh_q != NW'(CAPACITY)) begin
        fresh_q <= fresh_q + NW'(1);
      end
      if (state_q == S_FGET) begin
        free_q <= link_rd;
      end
      if (state_q == S_UNLINK) begin
        free_q <= cur_q;
        if (count_q != '0) begin
          count_q <= count_q - NW'(1);
        end
      end
      if (state_q == S_WRITE) begin
        count_q <= count_q + NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (bkt_we) begin
      bkt_mem[bkt_q] <= bkt_wdata;
    end
    bkt_rd_q <= bkt_mem[bkt_q];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_q    <= op_e'(kind_i);
          key_q   <= key_i;
          found_q <= 1'b0;
          rej_q   <= 1'b0;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          bkt_q <= hash_bkt;
        end
      end
      S_BHEAD: begin
        cur_q   <= bvalid_q[bkt_q] ? bkt_rd_q : Nil;
        prev_q  <= Nil;
        steps_q <= '0;
      end
      S_NCHK: begin
        if (key_rd == key_q) begin
          found_q <= 1'b1;
        end else begin
          prev_q  <= cur_q;
          cur_q   <= link_rd;
          steps_q <= steps_q + NW'(1);
        end
      end
      S_DECIDE: begin
        if (op_q == OP_ADD && !found_q && free_q == Nil) begin
          if (fresh_q != NW'(CAPACITY)) begin
            new_q <= fresh_q;
          end else begin
            rej_q <= 1'b1;
          end
        end
      end
      S_FREQ: new_q <= free_q;
      default: begin
        new_q <= new_q;
      end
    endcase
  end

  assign count_ext       = (NW + TotalW)'(count_q);
  assign found_o         = found_q;
  assign rejected_full_o = rej_q;
  assign item_total_o    = count_ext[TotalW-1:0];

  `CHS_ASSERT_ALWAYS(a_ready_excl, !(in_ready_o && out_valid_o), "ready and result valid together")
  `CHS_ASSERT(a_count_cap, count_q <= NW'(CAPACITY), "key count above capacity")
  `CHS_ASSERT(a_fresh_cap, fresh_q <= NW'(CAPACITY), "fresh index above capacity")
  `CHS_ASSERT(a_busy_after, in_fire |=> !in_ready_o, "ready straight after a transfer")

endmodule
`default_nettype wire
